[sv/pwrm_pkg.sv]
package pwrm_pkg;

	// Ring depth and data widths
	localparam int unsigned MAX_PEAKS = 16;
	localparam int unsigned PEAK_W    = 16;
	localparam int unsigned CFG_W     = 5;
	localparam int unsigned IDX_W     = (MAX_PEAKS > 1) ? $clog2(MAX_PEAKS) : 1;
	localparam int unsigned ECNT_W    = $clog2(MAX_PEAKS + 1);
	localparam int unsigned SQ_W      = 2 * PEAK_W;
	localparam int unsigned SUM_W     = SQ_W + $clog2(MAX_PEAKS);

	// Step counters of the serial units
	localparam int unsigned BIT_CNT_W  = $clog2(PEAK_W);
	localparam int unsigned DIV_CNT_W  = $clog2(SUM_W);
	localparam int unsigned ROOT_CNT_W = $clog2(PEAK_W);

	localparam logic [CFG_W-1:0]  CFG_RESET   = CFG_W'(16);
	localparam logic [PEAK_W-1:0] PEAK_OFFSET = PEAK_W'(32768);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_SQ,
		ST_DIV,
		ST_SQRT,
		ST_EMIT
	} top_state_t;

	typedef enum logic [1:0] {
		SQ_IDLE,
		SQ_READ,
		SQ_LOAD,
		SQ_MUL
	} sq_state_t;

	// Zero acts as one, anything above the ring depth as the depth
	function automatic logic [ECNT_W-1:0] eff_count(input logic [CFG_W-1:0] cfg);
		logic [ECNT_W-1:0] res;
		if (cfg == '0) begin
			res = ECNT_W'(1);
		end else if (int'(cfg) > int'(MAX_PEAKS)) begin
			res = ECNT_W'(MAX_PEAKS);
		end else begin
			res = ECNT_W'(cfg);
		end
		return res;
	endfunction

endpackage

[sv/pwrm_sqacc.sv]
module pwrm_sqacc (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          wr_en,
	input  logic [pwrm_pkg::IDX_W-1:0]    wr_addr,
	input  logic [pwrm_pkg::PEAK_W-1:0]   wr_data,
	input  logic                          start,
	input  logic [pwrm_pkg::ECNT_W-1:0]   count,
	output logic                          done,
	output logic [pwrm_pkg::SUM_W-1:0]    sum
);
	import pwrm_pkg::*;

	logic [PEAK_W-1:0]    store_q [MAX_PEAKS];
	logic [PEAK_W-1:0]    rd_q;
	sq_state_t            state_q, state_d;
	logic [IDX_W-1:0]     idx_q;
	logic [BIT_CNT_W-1:0] bit_q;
	logic                 done_q, done_d;
	logic [SQ_W-1:0]      mcand_q;
	logic [PEAK_W-1:0]    mplier_q;
	logic [SUM_W-1:0]     sum_q;
	logic                 last_bit, last_idx;

	// Peak store: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			store_q[wr_addr] <= wr_data;
		end
		rd_q <= store_q[idx_q];
	end

	assign last_bit = (bit_q == BIT_CNT_W'(PEAK_W - 1));
	assign last_idx = (ECNT_W'(idx_q) == count - ECNT_W'(1));

	// Sweep: read entry, load shifters, one multiplier bit per cycle
	always_comb begin
		state_d = state_q;
		done_d  = 1'b0;
		unique case (state_q)
			SQ_IDLE: if (start) state_d = SQ_READ;
			SQ_READ: state_d = SQ_LOAD;
			SQ_LOAD: state_d = SQ_MUL;
			SQ_MUL: begin
				if (last_bit) begin
					if (last_idx) begin
						state_d = SQ_IDLE;
						done_d  = 1'b1;
					end else begin
						state_d = SQ_READ;
					end
				end
			end
			default: state_d = SQ_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= SQ_IDLE;
			done_q  <= 1'b0;
			idx_q   <= '0;
			bit_q   <= '0;
		end else begin
			state_q <= state_d;
			done_q  <= done_d;
			if (state_q == SQ_IDLE && start) begin
				idx_q <= '0;
			end else if (state_q == SQ_MUL && last_bit) begin
				idx_q <= idx_q + IDX_W'(1);
			end
			if (state_q == SQ_LOAD) begin
				bit_q <= '0;
			end else if (state_q == SQ_MUL) begin
				bit_q <= bit_q + BIT_CNT_W'(1);
			end
		end
	end

	// Shift-and-add square, accumulated straight into the sum
	always_ff @(posedge clk) begin
		case (state_q)
			SQ_IDLE: if (start) sum_q <= '0;
			SQ_LOAD: begin
				mcand_q  <= SQ_W'(rd_q);
				mplier_q <= rd_q;
			end
			SQ_MUL: begin
				if (mplier_q[0]) begin
					sum_q <= sum_q + SUM_W'(mcand_q);
				end
				mcand_q  <= mcand_q << 1;
				mplier_q <= mplier_q >> 1;
			end
			default: ;
		endcase
	end

	assign done = done_q;
	assign sum  = sum_q;

endmodule

[sv/pwrm_div.sv]
module pwrm_div (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pwrm_pkg::SUM_W-1:0]    dividend,
	input  logic [pwrm_pkg::ECNT_W-1:0]   divisor,
	output logic                          done,
	output logic [pwrm_pkg::SQ_W-1:0]     quotient
);
	import pwrm_pkg::*;

	logic                 busy_q, done_q;
	logic [DIV_CNT_W-1:0] step_q;
	logic [SUM_W-1:0]     dvd_q;
	logic [ECNT_W-1:0]    rem_q;
	logic [ECNT_W:0]      trial, diff;
	logic                 ge;

	// Restoring division, one quotient bit per cycle
	assign trial = {rem_q, dvd_q[SUM_W-1]};
	assign diff  = trial - {1'b0, divisor};
	assign ge    = (trial >= {1'b0, divisor});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + DIV_CNT_W'(1);
				if (step_q == DIV_CNT_W'(SUM_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			dvd_q <= dividend;
			rem_q <= '0;
		end else if (busy_q) begin
			rem_q <= ge ? diff[ECNT_W-1:0] : trial[ECNT_W-1:0];
			dvd_q <= {dvd_q[SUM_W-2:0], ge};
		end
	end

	// Quotient never exceeds the largest square
	assign quotient = dvd_q[SQ_W-1:0];
	assign done     = done_q;

endmodule

[sv/pwrm_isqrt.sv]
module pwrm_isqrt (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          start,
	input  logic [pwrm_pkg::SQ_W-1:0]     radicand,
	output logic                          done,
	output logic [pwrm_pkg::PEAK_W-1:0]   root
);
	import pwrm_pkg::*;

	logic                  busy_q, done_q;
	logic [ROOT_CNT_W-1:0] step_q;
	logic [SQ_W-1:0]       rad_q;
	logic [PEAK_W:0]       rem_q;
	logic [PEAK_W-1:0]     root_q;
	logic [PEAK_W+2:0]     rem_sh, trial, diff;
	logic                  ge;

	// Digit-by-digit square root, two radicand bits per cycle
	assign rem_sh = {rem_q, rad_q[SQ_W-1 -: 2]};
	assign trial  = {1'b0, root_q, 2'b01};
	assign diff   = rem_sh - trial;
	assign ge     = (rem_sh >= trial);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			step_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				step_q <= step_q + ROOT_CNT_W'(1);
				if (step_q == ROOT_CNT_W'(PEAK_W - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			rad_q  <= radicand;
			rem_q  <= '0;
			root_q <= '0;
		end else if (busy_q) begin
			rem_q  <= ge ? diff[PEAK_W:0] : rem_sh[PEAK_W:0];
			root_q <= {root_q[PEAK_W-2:0], ge};
			rad_q  <= rad_q << 2;
		end
	end

	assign root = root_q;
	assign done = done_q;

endmodule

[sv/peak_window_rms_meter.sv]
// Peak-window RMS level meter.
// Input channel (in_valid/in_ready): one signed audio sample per transaction,
// with period_end set on the last sample of a period. Output channel
// (out_valid/out_ready): one transaction per sample carrying period_end, with
// the period peak (sample + 32768), an average_valid flag and the last level.
// A sample without period_end is taken and gives no output.
// A period end that does not close the ring passes through the EMIT state to
// the output register. One that closes the ring first runs the serial sum of
// squares over the stored peaks, then the divider and then the square root.
// in_ready is low while that work is in progress.
// A finished result waits in the EMIT state until the output register is free;
// in_ready is low there too, so no samples or period ends are taken meanwhile.
// cfg_we/cfg_data write peak_count (0 acts as 1, above 16 as 16) and must only
// be used while the block is idle.
// Reset clears the running peak, ring position and held level and sets
// peak_count to 16; ring entries are undefined until written.
module peak_window_rms_meter (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          cfg_we,
	input  logic [pwrm_pkg::CFG_W-1:0]    cfg_data,
	input  logic                          in_valid,
	output logic                          in_ready,
	input  logic signed [15:0]            sample,
	input  logic                          period_end,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [pwrm_pkg::PEAK_W-1:0]   period_peak,
	output logic                          average_valid,
	output logic [pwrm_pkg::PEAK_W-1:0]   level_average
);
	import pwrm_pkg::*;

	top_state_t        state_q, state_d;
	logic [CFG_W-1:0]  cfg_q;
	logic [PEAK_W-1:0] run_peak_q, held_avg_q;
	logic [IDX_W-1:0]  pos_q;
	logic [PEAK_W-1:0] res_peak_q;
	logic              res_avg_q;
	logic              out_valid_q;
	logic [PEAK_W-1:0] out_peak_q, out_level_q;
	logic              out_avg_q;

	logic              acc, end_acc, wrap, load_out;
	logic              sq_start, div_start, sqrt_start;
	logic              sq_done, div_done, sqrt_done;
	logic [PEAK_W-1:0] offset, new_peak;
	logic [ECNT_W-1:0] cnt_eff, next_pos;
	logic [SUM_W-1:0]  sum;
	logic [SQ_W-1:0]   quot;
	logic [PEAK_W-1:0] root;

	// Offset-binary sample and updated running peak
	assign offset   = PEAK_W'(sample) ^ PEAK_OFFSET;
	assign new_peak = (offset > run_peak_q) ? offset : run_peak_q;

	assign acc      = in_valid && in_ready;
	assign end_acc  = acc && period_end;
	assign cnt_eff  = eff_count(cfg_q);
	assign next_pos = ECNT_W'(pos_q) + ECNT_W'(1);
	assign wrap     = (next_pos >= cnt_eff);
	assign in_ready = (state_q == ST_IDLE);

	// Sequencer over the three serial units
	always_comb begin
		state_d    = state_q;
		sq_start   = 1'b0;
		div_start  = 1'b0;
		sqrt_start = 1'b0;
		load_out   = 1'b0;
		unique case (state_q)
			ST_IDLE: begin
				if (end_acc) begin
					state_d  = wrap ? ST_SQ : ST_EMIT;
					sq_start = wrap;
				end
			end
			ST_SQ: begin
				if (sq_done) begin
					state_d   = ST_DIV;
					div_start = 1'b1;
				end
			end
			ST_DIV: begin
				if (div_done) begin
					state_d    = ST_SQRT;
					sqrt_start = 1'b1;
				end
			end
			ST_SQRT: if (sqrt_done) state_d = ST_EMIT;
			ST_EMIT: begin
				if (!out_valid_q || out_ready) begin
					load_out = 1'b1;
					state_d  = ST_IDLE;
				end
			end
			default: state_d = ST_IDLE;
		endcase
	end

	// Control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_IDLE;
			cfg_q       <= CFG_RESET;
			run_peak_q  <= '0;
			pos_q       <= '0;
			held_avg_q  <= '0;
			out_valid_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				cfg_q <= cfg_data;
			end
			if (acc) begin
				run_peak_q <= period_end ? '0 : new_peak;
			end
			if (end_acc) begin
				pos_q <= wrap ? '0 : next_pos[IDX_W-1:0];
			end
			if (sqrt_done) begin
				held_avg_q <= root;
			end
			if (load_out) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Pending result and output register
	always_ff @(posedge clk) begin
		if (end_acc) begin
			res_peak_q <= new_peak;
			res_avg_q  <= wrap;
		end
		if (load_out) begin
			out_peak_q  <= res_peak_q;
			out_avg_q   <= res_avg_q;
			out_level_q <= held_avg_q;
		end
	end

	pwrm_sqacc u_sqacc (
		.clk     (clk),
		.arst_n  (arst_n),
		.wr_en   (end_acc),
		.wr_addr (pos_q),
		.wr_data (new_peak),
		.start   (sq_start),
		.count   (cnt_eff),
		.done    (sq_done),
		.sum     (sum)
	);

	pwrm_div u_div (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (div_start),
		.dividend (sum),
		.divisor  (cnt_eff),
		.done     (div_done),
		.quotient (quot)
	);

	pwrm_isqrt u_isqrt (
		.clk      (clk),
		.arst_n   (arst_n),
		.start    (sqrt_start),
		.radicand (quot),
		.done     (sqrt_done),
		.root     (root)
	);

	assign out_valid     = out_valid_q;
	assign period_peak   = out_peak_q;
	assign average_valid = out_avg_q;
	assign level_average = out_level_q;

`ifndef SYNTHESIS
	a_sq_done_in_sq: assert property (@(posedge clk) disable iff (!arst_n)
		sq_done |-> state_q == ST_SQ)
		else $error("sum of squares finished outside its phase");
	a_div_done_in_div: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> state_q == ST_DIV)
		else $error("divider finished outside its phase");
	a_sqrt_done_in_sqrt: assert property (@(posedge clk) disable iff (!arst_n)
		sqrt_done |-> state_q == ST_SQRT)
		else $error("square root finished outside its phase");
	a_load_from_emit: assert property (@(posedge clk) disable iff (!arst_n)
		$rose(out_valid_q) |-> $past(state_q) == ST_EMIT)
		else $error("output loaded without a pending result");
`endif

endmodule
